// ----- rtl/core/cfgtok_pkg.sv -----
// Shared types, constants and character helpers for the text tokenizer.
package cfgtok_pkg;

   localparam int HELD_DEPTH = 32;
   localparam int LINE_WIDTH = 24;
   localparam int HELD_AW    = $clog2(HELD_DEPTH);
   localparam int HELD_CW    = $clog2(HELD_DEPTH + 1);
   localparam int FQ_DEPTH   = 4;
   localparam int FQ_AW      = $clog2(FQ_DEPTH);
   localparam int FQ_CW      = $clog2(FQ_DEPTH + 1);

   localparam logic [LINE_WIDTH-1:0] LINE_TOP = {LINE_WIDTH{1'b1}};

   // result kinds
   localparam logic [1:0] RK_PAYLOAD = 2'd0;
   localparam logic [1:0] RK_TOKEN   = 2'd1;
   localparam logic [1:0] RK_ERROR   = 2'd2;

   // token kinds
   localparam logic [3:0] TK_EOF    = 4'd0;
   localparam logic [3:0] TK_LBRACE = 4'd1;
   localparam logic [3:0] TK_RBRACE = 4'd2;
   localparam logic [3:0] TK_EQUAL  = 4'd3;
   localparam logic [3:0] TK_DOT    = 4'd4;
   localparam logic [3:0] TK_LBRACK = 4'd5;
   localparam logic [3:0] TK_RBRACK = 4'd6;
   localparam logic [3:0] TK_COMMA  = 4'd7;
   localparam logic [3:0] TK_STRING = 4'd8;
   localparam logic [3:0] TK_NUMBER = 4'd9;
   localparam logic [3:0] TK_TRUE   = 4'd10;
   localparam logic [3:0] TK_FALSE  = 4'd11;
   localparam logic [3:0] TK_NAME   = 4'd12;

   // error codes
   localparam logic [2:0] ER_NONE      = 3'd0;
   localparam logic [2:0] ER_NL_STRING = 3'd1;
   localparam logic [2:0] ER_ESCAPE    = 3'd2;
   localparam logic [2:0] ER_GARBAGE   = 3'd3;
   localparam logic [2:0] ER_DIRECTIVE = 3'd4;
   localparam logic [2:0] ER_SYMBOL    = 3'd5;
   localparam logic [2:0] ER_OVERFLOW  = 3'd6;

   // keyword progress markers
   localparam logic [3:0] KP_TRUE_DONE  = 4'd4;
   localparam logic [3:0] KP_FALSE_ONE  = 4'd9;
   localparam logic [3:0] KP_FALSE_DONE = 4'd13;
   localparam logic [3:0] KP_BEGIN_DONE = 4'd5;
   localparam logic [3:0] KP_DEAD       = 4'd15;

   // terminator progress markers
   localparam logic [2:0] TP_FULL     = 3'd4;
   localparam logic [2:0] TP_MISMATCH = 3'd7;

   typedef struct packed {
      logic       eof;
      logic [7:0] ch;
      logic       sp;
      logic       dig;
      logic       alp;
      logic       wrd;
   } item_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [3:0]            tok;
      logic [7:0]            ch;
      logic [LINE_WIDTH-1:0] line;
      logic [2:0]            err;
   } result_type;

   typedef enum logic [9:0] {
      M_IDLE        = 10'b0000000001,
      M_COMMENT     = 10'b0000000010,
      M_STRING      = 10'b0000000100,
      M_ESCAPE      = 10'b0000001000,
      M_NUMBER      = 10'b0000010000,
      M_NAME        = 10'b0000100000,
      M_DIRECTIVE   = 10'b0001000000,
      M_AFTER_BEGIN = 10'b0010000000,
      M_BLOCK       = 10'b0100000000,
      M_HALTED      = 10'b1000000000
   } mode_type;

   typedef enum logic [3:0] {
      PH_RUN        = 4'b0001,
      PH_FLUSH_RD   = 4'b0010,
      PH_FLUSH_EMIT = 4'b0100,
      PH_POST       = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      POST_EOF = 3'b001,
      POST_NL  = 3'b010,
      POST_MIS = 3'b100
   } post_type;

   function automatic result_type make_res(input logic [1:0] kind, input logic [3:0] tok,
                                           input logic [7:0] ch,
                                           input logic [LINE_WIDTH-1:0] line,
                                           input logic [2:0] err);
      result_type r;
      r.kind = kind;
      r.tok  = tok;
      r.ch   = ch;
      r.line = line;
      r.err  = err;
      return r;
   endfunction

   function automatic logic [7:0] true_char(input logic [3:0] p);
      logic [7:0] c;
      case (p)
         4'd1:    c = "r";
         4'd2:    c = "u";
         4'd3:    c = "e";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] false_char(input logic [3:0] p);
      logic [7:0] c;
      case (p)
         4'd9:    c = "a";
         4'd10:   c = "l";
         4'd11:   c = "s";
         4'd12:   c = "e";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] begin_char(input logic [3:0] p);
      logic [7:0] c;
      case (p)
         4'd0:    c = "b";
         4'd1:    c = "e";
         4'd2:    c = "g";
         4'd3:    c = "i";
         4'd4:    c = "n";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] end_char(input logic [2:0] p);
      logic [7:0] c;
      case (p)
         3'd0:    c = "%";
         3'd1:    c = "e";
         3'd2:    c = "n";
         3'd3:    c = "d";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/core/config_text_tokenizer.sv -----
// Top level of the streaming text tokenizer.
//
//  channel   direction  handshake      payload
//  req_*     in         push / full    req_data_byte, req_end_of_input
//  rsp_*     out        empty / pop    kind, token, char, line, error, last
//
// One scanner step per cycle while the staging register is free or can move on. A byte that ends
// a number, name or %begin, or end of input inside an open token, stays queued and is scanned
// again; end of input after %begin also passes after-begin mode. A block newline not after %end,
// a byte breaking a terminator or end of input in block flushes held bytes (read then emit per byte).
// A four-entry input queue decouples the front from the scanner; a staging
// register and an output register sit before rsp. Reset is synchronous; after an error the
// block drops input until reset.
module config_text_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_input,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_result_kind,
   output logic [3:0]  rsp_token_kind,
   output logic [7:0]  rsp_payload_char,
   output logic [cfgtok_pkg::LINE_WIDTH-1:0] rsp_line_number,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last_of_input
);
   import cfgtok_pkg::*;

   logic       item_vld;
   item_type   item;
   logic       item_pop;
   result_type res_out;

   cfgtok_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .item_vld         (item_vld),
      .item             (item),
      .item_pop         (item_pop)
   );

   cfgtok_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .item_vld (item_vld),
      .item     (item),
      .item_pop (item_pop),
      .empty    (empty),
      .pop      (pop),
      .res_out  (res_out),
      .res_last (rsp_last_of_input)
   );

   assign rsp_result_kind  = res_out.kind;
   assign rsp_token_kind   = res_out.tok;
   assign rsp_payload_char = res_out.ch;
   assign rsp_line_number  = res_out.line;
   assign rsp_error_code   = res_out.err;

endmodule

// ----- rtl/core/cfgtok_ram.sv -----
// Generic single-port-write, registered-read RAM.
module cfgtok_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/cfgtok_front.sv -----
// Front end: accepts bytes, classifies them and queues them for the engine.
module cfgtok_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_end_of_input,
   output logic                  item_vld,
   output cfgtok_pkg::item_type  item,
   input  logic                  item_pop
);
   import cfgtok_pkg::*;

   item_type          fq_ff [FQ_DEPTH];
   logic [FQ_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FQ_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FQ_CW-1:0]  cnt_ff, cnt_in;
   item_type          cls;
   logic              push_acc;
   logic              pop_acc;
   logic [7:0]        c;

   // character classes
   always_comb begin
      c       = req_data_byte;
      cls.eof = req_end_of_input;
      cls.ch  = c;
      cls.sp  = (c == " ") || (c >= 8'd9 && c <= 8'd13);
      cls.dig = (c >= "0" && c <= "9");
      cls.alp = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      cls.wrd = cls.alp || cls.dig || (c == "_");
   end

   assign full     = (cnt_ff == FQ_CW'(FQ_DEPTH));
   assign push_acc = push && !full;
   assign item_vld = (cnt_ff != '0);
   assign pop_acc  = item_pop && item_vld;
   assign item     = fq_ff[rd_ptr_ff];

   // pointers and fill count
   always_comb begin
      wr_ptr_in = push_acc ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_acc ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_acc && !pop_acc) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_acc && !push_acc) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_acc) begin
         fq_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- rtl/core/cfgtok_engine.sv -----
// Back end: scanner state machine, held-line buffer and result staging.
module cfgtok_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_vld,
   input  cfgtok_pkg::item_type    item,
   output logic                    item_pop,
   output logic                    empty,
   input  logic                    pop,
   output cfgtok_pkg::result_type  res_out,
   output logic                    res_last
);
   import cfgtok_pkg::*;

   mode_type               mode_ff, mode_in;
   phase_type              phase_ff, phase_in;
   post_type               post_ff, post_in;
   logic [LINE_WIDTH-1:0]  line_ff, line_in, line_inc;
   logic [3:0]             kp_ff, kp_in;
   logic [HELD_CW-1:0]     held_ff, held_in;
   logic [2:0]             tp_ff, tp_in;
   logic [HELD_CW-1:0]     fidx_ff, fidx_in;
   logic [HELD_CW-1:0]     fend_ff, fend_in;
   result_type             stg_ff, stg_in;
   logic                   stg_vld_ff, stg_vld_in;
   logic                   stg_last_ff, stg_last_in;
   result_type             out_ff, out_in;
   logic                   out_vld_ff, out_vld_in;
   logic                   out_last_ff, out_last_in;

   logic                   out_free, pop_acc, step_en, run, stg_move;
   logic                   emit, done, keep;
   result_type             res;
   logic [7:0]             c;
   logic                   wr_en, rd_en;
   logic [HELD_AW-1:0]     wr_addr, rd_addr;
   logic [7:0]             rd_data;

   cfgtok_ram #(.WIDTH(8), .DEPTH(HELD_DEPTH)) u_held (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (c),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign c        = item.ch;
   assign line_inc = (line_ff == LINE_TOP) ? line_ff : line_ff + 1'b1;
   assign pop_acc  = pop && out_vld_ff;
   assign out_free = !out_vld_ff || pop_acc;
   assign step_en  = !stg_vld_ff || out_free;
   assign run      = step_en && item_vld;
   assign wr_addr  = held_ff[HELD_AW-1:0];
   assign rd_addr  = fidx_ff[HELD_AW-1:0];

   // one scanner step per cycle while run is high, at most one result
   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      post_in  = post_ff;
      line_in  = line_ff;
      kp_in    = kp_ff;
      held_in  = held_ff;
      tp_in    = tp_ff;
      fidx_in  = fidx_ff;
      fend_in  = fend_ff;
      emit     = 1'b0;
      done     = 1'b0;
      keep     = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      res      = make_res(RK_PAYLOAD, TK_EOF, c, line_ff, ER_NONE);

      if (run) begin
         case (phase_ff)
            PH_FLUSH_RD: begin
               if (fidx_ff == fend_ff) begin
                  phase_in = PH_POST;
               end else begin
                  rd_en    = 1'b1;
                  phase_in = PH_FLUSH_EMIT;
               end
            end
            PH_FLUSH_EMIT: begin
               emit     = 1'b1;
               res.ch   = rd_data;
               fidx_in  = fidx_ff + 1'b1;
               phase_in = PH_FLUSH_RD;
            end
            PH_POST: begin
               held_in  = '0;
               phase_in = PH_RUN;
               emit     = 1'b1;
               case (post_ff)
                  POST_EOF: begin
                     res     = make_res(RK_TOKEN, TK_STRING, 8'h00, line_ff, ER_NONE);
                     tp_in   = '0;
                     mode_in = M_IDLE;
                     kp_in   = '0;
                  end
                  POST_NL: begin
                     res.ch  = 8'h0A;
                     line_in = line_inc;
                     tp_in   = '0;
                     done    = 1'b1;
                  end
                  default: begin
                     tp_in = TP_MISMATCH;
                     done  = 1'b1;
                  end
               endcase
            end
            default: begin
               case (mode_ff)
                  M_IDLE: begin
                     done = 1'b1;
                     if (item.eof) begin
                        emit = 1'b1;
                        res  = make_res(RK_TOKEN, TK_EOF, 8'h00, line_ff, ER_NONE);
                     end else if (item.sp) begin
                        if (c == 8'h0A) begin
                           line_in = line_inc;
                        end
                     end else if (c == "#") begin
                        mode_in = M_COMMENT;
                     end else if (c == "\"") begin
                        mode_in = M_STRING;
                     end else if (c == "%") begin
                        mode_in = M_DIRECTIVE;
                        kp_in   = '0;
                     end else if (c == "{" || c == "}" || c == "=" || c == "." ||
                                  c == "[" || c == "]" || c == ",") begin
                        emit = 1'b1;
                        res  = make_res(RK_TOKEN, TK_EOF, 8'h00, line_ff, ER_NONE);
                        case (c)
                           "{":     res.tok = TK_LBRACE;
                           "}":     res.tok = TK_RBRACE;
                           "=":     res.tok = TK_EQUAL;
                           ".":     res.tok = TK_DOT;
                           "[":     res.tok = TK_LBRACK;
                           "]":     res.tok = TK_RBRACK;
                           default: res.tok = TK_COMMA;
                        endcase
                     end else if (item.dig || c == "-") begin
                        emit    = 1'b1;
                        mode_in = M_NUMBER;
                     end else if (item.alp || c == "_") begin
                        emit    = 1'b1;
                        mode_in = M_NAME;
                        kp_in   = (c == "t") ? 4'd1 : (c == "f") ? KP_FALSE_ONE : KP_DEAD;
                     end else begin
                        emit    = 1'b1;
                        res     = make_res(RK_ERROR, TK_EOF, 8'h00, line_ff, ER_SYMBOL);
                        mode_in = M_HALTED;
                     end
                  end
                  M_COMMENT: begin
                     if (item.eof) begin
                        mode_in = M_IDLE;
                        kp_in   = '0;
                     end else begin
                        done = 1'b1;
                        if (c == 8'h0A) begin
                           line_in = line_inc;
                           mode_in = M_IDLE;
                           kp_in   = '0;
                        end
                     end
                  end
                  M_STRING: begin
                     if (item.eof || c == "\"") begin
                        emit    = 1'b1;
                        res     = make_res(RK_TOKEN, TK_STRING, 8'h00, line_ff, ER_NONE);
                        mode_in = M_IDLE;
                        kp_in   = '0;
                        done    = !item.eof;
                     end else begin
                        done = 1'b1;
                        if (c == 8'h0A) begin
                           emit    = 1'b1;
                           res     = make_res(RK_ERROR, TK_EOF, 8'h00, line_ff, ER_NL_STRING);
                           mode_in = M_HALTED;
                        end else if (c == "\\") begin
                           mode_in = M_ESCAPE;
                        end else begin
                           emit = 1'b1;
                        end
                     end
                  end
                  M_ESCAPE: begin
                     done = 1'b1;
                     emit = 1'b1;
                     if (!item.eof && (c == "n" || c == "t" || c == "\\" || c == "\"")) begin
                        mode_in = M_STRING;
                        if (c == "n") begin
                           res.ch = 8'h0A;
                        end else if (c == "t") begin
                           res.ch = 8'h09;
                        end
                     end else begin
                        res     = make_res(RK_ERROR, TK_EOF, 8'h00, line_ff, ER_ESCAPE);
                        mode_in = M_HALTED;
                     end
                  end
                  M_NUMBER: begin
                     emit = 1'b1;
                     if (!item.eof && item.dig) begin
                        done = 1'b1;
                     end else begin
                        res     = make_res(RK_TOKEN, TK_NUMBER, 8'h00, line_ff, ER_NONE);
                        mode_in = M_IDLE;
                        kp_in   = '0;
                     end
                  end
                  M_NAME: begin
                     emit = 1'b1;
                     if (!item.eof && item.wrd) begin
                        done = 1'b1;
                        if (kp_ff >= 4'd1 && kp_ff <= 4'd3 && c == true_char(kp_ff)) begin
                           kp_in = kp_ff + 1'b1;
                        end else if (kp_ff >= KP_FALSE_ONE && kp_ff <= 4'd12 &&
                                     c == false_char(kp_ff)) begin
                           kp_in = kp_ff + 1'b1;
                        end else begin
                           kp_in = KP_DEAD;
                        end
                     end else begin
                        res = make_res(RK_TOKEN, TK_NAME, 8'h00, line_ff, ER_NONE);
                        if (kp_ff == KP_TRUE_DONE) begin
                           res.tok = TK_TRUE;
                        end else if (kp_ff == KP_FALSE_DONE) begin
                           res.tok = TK_FALSE;
                        end
                        mode_in = M_IDLE;
                        kp_in   = '0;
                     end
                  end
                  M_DIRECTIVE: begin
                     if (!item.eof && item.wrd) begin
                        done  = 1'b1;
                        kp_in = (kp_ff < KP_BEGIN_DONE && c == begin_char(kp_ff)) ?
                                kp_ff + 1'b1 : KP_DEAD;
                     end else if (kp_ff != KP_BEGIN_DONE) begin
                        done    = 1'b1;
                        emit    = 1'b1;
                        res     = make_res(RK_ERROR, TK_EOF, 8'h00, line_ff, ER_DIRECTIVE);
                        mode_in = M_HALTED;
                     end else begin
                        kp_in   = '0;
                        mode_in = M_AFTER_BEGIN;
                     end
                  end
                  M_AFTER_BEGIN: begin
                     if (item.eof) begin
                        emit    = 1'b1;
                        res     = make_res(RK_TOKEN, TK_STRING, 8'h00, line_ff, ER_NONE);
                        mode_in = M_IDLE;
                        kp_in   = '0;
                     end else begin
                        done = 1'b1;
                        if (c == 8'h0A) begin
                           line_in = line_inc;
                           mode_in = M_BLOCK;
                           held_in = '0;
                           tp_in   = '0;
                        end else if (!item.sp) begin
                           emit    = 1'b1;
                           res     = make_res(RK_ERROR, TK_EOF, 8'h00, line_ff, ER_GARBAGE);
                           mode_in = M_HALTED;
                        end
                     end
                  end
                  M_BLOCK: begin
                     fidx_in = '0;
                     if (item.eof) begin
                        phase_in = PH_FLUSH_RD;
                        post_in  = POST_EOF;
                        fend_in  = (tp_ff == TP_FULL || tp_ff == TP_MISMATCH) ? '0 : held_ff;
                     end else if (c == 8'h0A) begin
                        if (tp_ff == TP_FULL) begin
                           done    = 1'b1;
                           emit    = 1'b1;
                           res     = make_res(RK_TOKEN, TK_STRING, 8'h00, line_inc, ER_NONE);
                           line_in = line_inc;
                           held_in = '0;
                           tp_in   = '0;
                           mode_in = M_IDLE;
                           kp_in   = '0;
                        end else begin
                           phase_in = PH_FLUSH_RD;
                           post_in  = POST_NL;
                           fend_in  = (tp_ff == TP_MISMATCH) ? '0 : held_ff;
                        end
                     end else if (tp_ff == TP_MISMATCH) begin
                        done = 1'b1;
                        emit = 1'b1;
                     end else begin
                        if (item.sp) begin
                           keep = (tp_ff == '0) || (tp_ff == TP_FULL);
                        end else begin
                           keep = (tp_ff < TP_FULL) && (c == end_char(tp_ff));
                        end
                        if (keep) begin
                           done = 1'b1;
                           if (held_ff >= HELD_CW'(HELD_DEPTH)) begin
                              emit    = 1'b1;
                              res     = make_res(RK_ERROR, TK_EOF, 8'h00, line_ff, ER_OVERFLOW);
                              mode_in = M_HALTED;
                           end else begin
                              wr_en   = 1'b1;
                              held_in = held_ff + 1'b1;
                              if (!item.sp) begin
                                 tp_in = tp_ff + 1'b1;
                              end
                           end
                        end else begin
                           phase_in = PH_FLUSH_RD;
                           post_in  = POST_MIS;
                           fend_in  = held_ff;
                        end
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         endcase
      end
   end

   assign item_pop = run && done;

   // staging register holds the newest result until its last flag is known
   always_comb begin
      stg_move    = stg_vld_ff && out_free && (stg_last_ff || (run && (emit || done)));
      stg_in      = stg_ff;
      stg_vld_in  = stg_vld_ff;
      stg_last_in = stg_last_ff;
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      out_last_in = out_last_ff;
      if (stg_move) begin
         out_in      = stg_ff;
         out_vld_in  = 1'b1;
         out_last_in = stg_last_ff || (run && done && !emit);
      end else if (pop_acc) begin
         out_vld_in = 1'b0;
      end
      if (run && emit) begin
         stg_in      = res;
         stg_vld_in  = 1'b1;
         stg_last_in = done;
      end else if (stg_move) begin
         stg_vld_in = 1'b0;
      end else if (run && done && stg_vld_ff) begin
         stg_last_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= M_IDLE;
         phase_ff    <= PH_RUN;
         post_ff     <= POST_EOF;
         line_ff     <= LINE_WIDTH'(1);
         kp_ff       <= '0;
         held_ff     <= '0;
         tp_ff       <= '0;
         fidx_ff     <= '0;
         fend_ff     <= '0;
         stg_vld_ff  <= 1'b0;
         stg_last_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         out_last_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         phase_ff    <= phase_in;
         post_ff     <= post_in;
         line_ff     <= line_in;
         kp_ff       <= kp_in;
         held_ff     <= held_in;
         tp_ff       <= tp_in;
         fidx_ff     <= fidx_in;
         fend_ff     <= fend_in;
         stg_vld_ff  <= stg_vld_in;
         stg_last_ff <= stg_last_in;
         out_vld_ff  <= out_vld_in;
         out_last_ff <= out_last_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      stg_ff <= stg_in;
      out_ff <= out_in;
   end

   assign empty    = !out_vld_ff;
   assign res_out  = out_ff;
   assign res_last = out_last_ff;

   // a halted scanner never leaves that mode before reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_HALTED |=> mode_ff == M_HALTED)
      else $error("scanner left halted mode");

   // the held count never passes the buffer depth
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HELD_CW'(HELD_DEPTH))
      else $error("held count overflow");

   // an error is always the final result of its transaction
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.kind == RK_ERROR |-> out_last_ff)
      else $error("error result not marked last");

   // an item leaves the queue only from the main scan phase or the post-flush phase
   a_pop_phase: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> phase_ff == PH_RUN || phase_ff == PH_POST)
      else $error("item popped during flush");

   // flush index stays inside the flush window
   a_flush_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FLUSH_EMIT |-> fidx_ff < fend_ff)
      else $error("flush index out of range");

endmodule
